>>> rtl/rbst_pkg.sv
// Shared definitions for the ray versus box slab test.
// No dependencies; imported by the core and its reciprocal unit.
`default_nettype none

package rbst_pkg;

	// Command codes carried in the cmd field of an input word.
	localparam logic CMD_LOAD_RAY = 1'b0;
	localparam logic CMD_TEST_BOX = 1'b1;

	// Number of spatial axes handled per word.
	localparam int NUM_AXES = 3;

endpackage

`default_nettype wire

>>> rtl/rbst_recip.sv
// Reciprocal unit: 2^(2*FRAC_BITS) / |d| by restoring division, one quotient bit per cycle.
// Depends on rbst_pkg for the command codes.
`default_nettype none

module rbst_recip #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          cmd,
	input  wire logic signed [COORD_WIDTH-1:0] dir,
	output logic             [COORD_WIDTH-1:0] inv_mag,
	output logic                               inv_neg,
	output logic                               busy
);
	import rbst_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int QW    = 2 * FRAC_BITS + 1;
	localparam int SW    = ((QW > CW) ? QW : CW) + 1;
	localparam int CNT_W = $clog2(2 * FRAC_BITS + 1);

	logic [CW-1:0]    dm_q;
	logic             neg_q;
	logic             par_q;
	logic [CW-1:0]    r_q;
	logic [QW-1:0]    q_q;
	logic [CNT_W-1:0] idx_q;
	logic             busy_q;
	logic [CW-1:0]    inv_mag_q;
	logic             inv_neg_q;

	logic             div_bit;
	logic [CW:0]      sh;
	logic             ge;
	logic [CW:0]      diff;
	logic [CW-1:0]    r_nx;
	logic [QW-1:0]    q_nx;
	logic [SW-1:0]    q_ext;
	logic [SW-1:0]    lim;
	logic [SW-1:0]    mag_sat;
	logic [CW-1:0]    dir_mag;
	logic             go;

	// The dividend has a single one bit, at position 2*FRAC_BITS.
	assign div_bit = (idx_q == CNT_W'(2 * FRAC_BITS));
	assign sh      = {r_q, div_bit};
	assign ge      = (sh >= {1'b0, dm_q});
	assign diff    = sh - {1'b0, dm_q};
	assign r_nx    = ge ? diff[CW-1:0] : sh[CW-1:0];
	assign q_nx    = {q_q[QW-2:0], ge};

	assign q_ext   = SW'(q_nx);
	assign lim     = neg_q ? (SW'(1) << (CW - 1)) : ((SW'(1) << (CW - 1)) - SW'(1));
	assign mag_sat = (q_ext > lim) ? lim : q_ext;

	assign dir_mag = dir[CW-1] ? (~dir + CW'(1)) : dir;
	assign go      = start && (cmd == CMD_LOAD_RAY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			idx_q     <= '0;
			inv_mag_q <= '0;
			inv_neg_q <= 1'b0;
		end else if (go) begin
			busy_q <= 1'b1;
			idx_q  <= CNT_W'(2 * FRAC_BITS);
		end else if (busy_q) begin
			if (idx_q == '0) begin
				busy_q <= 1'b0;
				if (par_q) begin
					inv_mag_q <= '0;
					inv_neg_q <= 1'b0;
				end else begin
					inv_mag_q <= mag_sat[CW-1:0];
					inv_neg_q <= neg_q && (mag_sat != '0);
				end
			end else begin
				idx_q <= idx_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dm_q  <= dir_mag;
			neg_q <= dir[CW-1];
			par_q <= (dir == '0);
			r_q   <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			r_q <= r_nx;
			q_q <= q_nx;
		end
	end

	assign inv_mag = inv_mag_q;
	assign inv_neg = inv_neg_q;
	assign busy    = busy_q;

endmodule

`default_nettype wire

>>> rtl/rbst_mul.sv
// Pipelined slab distance multiplier: magnitude product, shift by FRAC_BITS, saturation.
// Three register stages; no package dependencies.
`default_nettype none

module rbst_mul #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic        [COORD_WIDTH-1:0] a,
	input  wire logic        [COORD_WIDTH-1:0] b,
	input  wire logic                          neg,
	output logic signed      [COORD_WIDTH-1:0] t
);
	localparam int CW = COORD_WIDTH;
	localparam int LO = CW / 2;
	localparam int HI = CW - LO;
	localparam int PW = 2 * CW;

	logic [2*LO-1:0] ll_s2;
	logic [CW-1:0]   lh_s2;
	logic [CW-1:0]   hl_s2;
	logic [2*HI-1:0] hh_s2;
	logic            neg_s2;
	logic [PW-1:0]   p_s3;
	logic            neg_s3;
	logic [CW-1:0]   t_s4;

	logic [PW-1:0]   sh;
	logic            ovf;
	logic [CW-1:0]   mag;
	logic [CW-1:0]   t_nx;

	// Partial products over the low and high halves of each operand, their sum, and the saturated result.
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s2  <= a[LO-1:0] * b[LO-1:0];
			lh_s2  <= a[LO-1:0] * b[CW-1:LO];
			hl_s2  <= a[CW-1:LO] * b[LO-1:0];
			hh_s2  <= a[CW-1:LO] * b[CW-1:LO];
			neg_s2 <= neg;
			p_s3   <= PW'(ll_s2) + (PW'(lh_s2) << LO) + (PW'(hl_s2) << LO)
				+ (PW'(hh_s2) << (2 * LO));
			neg_s3 <= neg_s2;
			t_s4   <= t_nx;
		end
	end

	always_comb begin
		sh  = p_s3 >> FRAC_BITS;
		ovf = |sh[PW-1:CW-1];
		mag = {1'b0, sh[CW-2:0]};
		if (!neg_s3) begin
			t_nx = ovf ? {1'b0, {(CW-1){1'b1}}} : mag;
		end else begin
			t_nx = ovf ? {1'b1, {(CW-1){1'b0}}} : (~mag + CW'(1));
		end
	end

	assign t = t_s4;

endmodule

`default_nettype wire

>>> rtl/ray_box_slab_test_core.sv
// Top level of the ray versus axis-aligned box slab test, signed fixed point.
// Depends on rbst_pkg, rbst_recip and rbst_mul.
`default_nettype none

//  Channel | Direction | Handshake            | Word contents
//  input   | in        | in_valid / in_stall  | cmd, first_*, second_*, t_low, t_high
//  output  | out       | out_valid / out_stall| hit, near_t
//
// A test-box word is accepted every cycle while in_stall is low; its result passes through
// one input stage, three multiplier stages, three axis stages that narrow the interval.
// A load-ray word produces no result and holds in_stall high while three restoring
// dividers form the reciprocals, one quotient bit per cycle.
// Reset clears the stored ray and all valid bits; no clearing pass is needed.
// When out_stall holds a waiting result, the whole pipeline freezes and nothing is lost.

module ray_box_slab_test_core #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          cmd,
	input  wire logic signed [COORD_WIDTH-1:0] first_x,
	input  wire logic signed [COORD_WIDTH-1:0] first_y,
	input  wire logic signed [COORD_WIDTH-1:0] first_z,
	input  wire logic signed [COORD_WIDTH-1:0] second_x,
	input  wire logic signed [COORD_WIDTH-1:0] second_y,
	input  wire logic signed [COORD_WIDTH-1:0] second_z,
	input  wire logic signed [COORD_WIDTH-1:0] t_low,
	input  wire logic signed [COORD_WIDTH-1:0] t_high,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               hit,
	output logic signed      [COORD_WIDTH-1:0] near_t
);
	import rbst_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int NA = NUM_AXES;

	typedef struct packed {
		logic                 hit;
		logic signed [CW-1:0] tn;
		logic signed [CW-1:0] tf;
	} slab_acc_t;

	// The interval is narrowed by one axis and hit clears when it empties; a parallel axis checks the origin span instead.
	function automatic slab_acc_t axis_step(
		input slab_acc_t            acc,
		input logic signed [CW-1:0] t0,
		input logic signed [CW-1:0] t1,
		input logic                 inv_neg,
		input logic                 par,
		input logic                 miss
	);
		slab_acc_t            r;
		logic signed [CW-1:0] a0;
		logic signed [CW-1:0] a1;
		r  = acc;
		a0 = inv_neg ? t1 : t0;
		a1 = inv_neg ? t0 : t1;
		if (par) begin
			if (miss) begin
				r.hit = 1'b0;
			end
		end else begin
			if (a0 > r.tn) begin
				r.tn = a0;
			end
			if (a1 < r.tf) begin
				r.tf = a1;
			end
		end
		if (r.tf <= r.tn) begin
			r.hit = 1'b0;
		end
		return r;
	endfunction

	logic                 adv;
	logic                 in_accept;
	logic                 load_go;
	logic                 div_busy;
	logic [NA-1:0]        busy_lane;

	logic signed [CW-1:0] fst [NA];
	logic signed [CW-1:0] snd [NA];

	// Stored ray.
	logic signed [CW-1:0] origin_q [NA];
	logic [NA-1:0]        par_q;
	logic [CW-1:0]        inv_mag [NA];
	logic [NA-1:0]        inv_neg;

	// Stage 1: slab differences and captured ray.
	logic                 valid_s1;
	logic [CW-1:0]        md_lo_s1 [NA];
	logic [CW-1:0]        md_hi_s1 [NA];
	logic [CW-1:0]        inv_mag_s1 [NA];
	logic [NA-1:0]        neg_lo_s1;
	logic [NA-1:0]        neg_hi_s1;
	logic [NA-1:0]        par_s1, miss_s1, inv_neg_s1;
	logic signed [CW-1:0] tl_s1, th_s1;

	logic [NA-1:0]        par_s2, miss_s2, inv_neg_s2;
	logic signed [CW-1:0] tl_s2, th_s2;
	logic                 valid_s2;
	logic [NA-1:0]        par_s3, miss_s3, inv_neg_s3;
	logic signed [CW-1:0] tl_s3, th_s3;
	logic                 valid_s3;
	logic [NA-1:0]        par_s4, miss_s4, inv_neg_s4;
	logic signed [CW-1:0] tl_s4, th_s4;
	logic                 valid_s4;

	logic signed [CW-1:0] t_lo_s4 [NA];
	logic signed [CW-1:0] t_hi_s4 [NA];

	// Axis stages.
	slab_acc_t            acc_s5, acc_s6;
	logic                 valid_s5, valid_s6, valid_s7;
	logic [NA-1:0]        par_s5, miss_s5, inv_neg_s5;
	logic [NA-1:0]        par_s6, miss_s6, inv_neg_s6;
	logic signed [CW-1:0] t_lo1_s5, t_hi1_s5, t_lo2_s5, t_hi2_s5;
	logic signed [CW-1:0] t_lo2_s6, t_hi2_s6;
	logic                 hit_s7;
	logic signed [CW-1:0] near_s7;

	slab_acc_t            acc_init;
	slab_acc_t            acc_nx5, acc_nx6, acc_nx7;

	assign fst[0] = first_x;
	assign fst[1] = first_y;
	assign fst[2] = first_z;
	assign snd[0] = second_x;
	assign snd[1] = second_y;
	assign snd[2] = second_z;

	// Every stage moves together unless a finished result is held at the output.
	assign adv       = !(valid_s7 && out_stall);
	assign div_busy  = |busy_lane;
	assign in_stall  = !adv || div_busy;
	assign in_accept = in_valid && !in_stall;
	assign load_go   = in_accept && (cmd == CMD_LOAD_RAY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NA; i++) begin
				origin_q[i] <= '0;
			end
			par_q <= '0;
		end else if (load_go) begin
			for (int i = 0; i < NA; i++) begin
				origin_q[i] <= fst[i];
				par_q[i]    <= (snd[i] == '0);
			end
		end
	end

	genvar g;
	generate
		for (g = 0; g < NA; g++) begin : g_axis
			rbst_recip #(
				.COORD_WIDTH(COORD_WIDTH),
				.FRAC_BITS  (FRAC_BITS)
			) u_recip (
				.clk    (clk),
				.arst_n (arst_n),
				.start  (in_accept),
				.cmd    (cmd),
				.dir    (snd[g]),
				.inv_mag(inv_mag[g]),
				.inv_neg(inv_neg[g]),
				.busy   (busy_lane[g])
			);

			rbst_mul #(
				.COORD_WIDTH(COORD_WIDTH),
				.FRAC_BITS  (FRAC_BITS)
			) u_mul_lo (
				.clk(clk),
				.en (adv),
				.a  (md_lo_s1[g]),
				.b  (inv_mag_s1[g]),
				.neg(neg_lo_s1[g] ^ inv_neg_s1[g]),
				.t  (t_lo_s4[g])
			);

			rbst_mul #(
				.COORD_WIDTH(COORD_WIDTH),
				.FRAC_BITS  (FRAC_BITS)
			) u_mul_hi (
				.clk(clk),
				.en (adv),
				.a  (md_hi_s1[g]),
				.b  (inv_mag_s1[g]),
				.neg(neg_hi_s1[g] ^ inv_neg_s1[g]),
				.t  (t_hi_s4[g])
			);
		end
	endgenerate

	// Valid bits travel with the words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_accept && (cmd == CMD_TEST_BOX);
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// Stage 1 takes the slab differences as sign and magnitude, and the current ray; side fields ride on to stage 4.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NA; i++) begin
				neg_lo_s1[i]  <= (fst[i] < origin_q[i]);
				neg_hi_s1[i]  <= (snd[i] < origin_q[i]);
				md_lo_s1[i]   <= (fst[i] < origin_q[i]) ? (origin_q[i] - fst[i])
					: (fst[i] - origin_q[i]);
				md_hi_s1[i]   <= (snd[i] < origin_q[i]) ? (origin_q[i] - snd[i])
					: (snd[i] - origin_q[i]);
				inv_mag_s1[i] <= inv_mag[i];
				miss_s1[i]    <= (origin_q[i] < fst[i]) || (origin_q[i] > snd[i]);
			end
			par_s1     <= par_q;
			inv_neg_s1 <= inv_neg;
			tl_s1      <= t_low;
			th_s1      <= t_high;

			par_s2     <= par_s1;
			miss_s2    <= miss_s1;
			inv_neg_s2 <= inv_neg_s1;
			tl_s2      <= tl_s1;
			th_s2      <= th_s1;

			par_s3     <= par_s2;
			miss_s3    <= miss_s2;
			inv_neg_s3 <= inv_neg_s2;
			tl_s3      <= tl_s2;
			th_s3      <= th_s2;

			par_s4     <= par_s3;
			miss_s4    <= miss_s3;
			inv_neg_s4 <= inv_neg_s3;
			tl_s4      <= tl_s3;
			th_s4      <= th_s3;
		end
	end

	// Axis stages: x in stage 5, y in stage 6, z in stage 7.
	always_comb begin
		acc_init.hit = 1'b1;
		acc_init.tn  = tl_s4;
		acc_init.tf  = th_s4;
		acc_nx5 = axis_step(acc_init, t_lo_s4[0], t_hi_s4[0], inv_neg_s4[0], par_s4[0],
			miss_s4[0]);
		acc_nx6 = axis_step(acc_s5, t_lo1_s5, t_hi1_s5, inv_neg_s5[1], par_s5[1],
			miss_s5[1]);
		acc_nx7 = axis_step(acc_s6, t_lo2_s6, t_hi2_s6, inv_neg_s6[2], par_s6[2],
			miss_s6[2]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s5     <= acc_nx5;
			par_s5     <= par_s4;
			miss_s5    <= miss_s4;
			inv_neg_s5 <= inv_neg_s4;
			t_lo1_s5   <= t_lo_s4[1];
			t_hi1_s5   <= t_hi_s4[1];
			t_lo2_s5   <= t_lo_s4[2];
			t_hi2_s5   <= t_hi_s4[2];

			acc_s6     <= acc_nx6;
			par_s6     <= par_s5;
			miss_s6    <= miss_s5;
			inv_neg_s6 <= inv_neg_s5;
			t_lo2_s6   <= t_lo2_s5;
			t_hi2_s6   <= t_hi2_s5;

			hit_s7     <= acc_nx7.hit;
			near_s7    <= acc_nx7.hit ? acc_nx7.tn : '0;
		end
	end

	assign out_valid = valid_s7;
	assign hit       = hit_s7;
	assign near_t    = near_s7;

endmodule

`default_nettype wire

>>> tb/tb_ray_box_slab_test_core.sv
// Self-checking testbench for ray_box_slab_test_core: random and directed ray loads
// and box tests, with a built-in slab predictor and an in-order result check.
// Depends on rbst_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_ray_box_slab_test_core;
	import rbst_pkg::*;

	localparam int CW = 32;
	localparam int FB = 16;
	localparam int LIMIT_CYCLES = 1500000;

	typedef struct {
		logic                 cmd;
		logic signed [CW-1:0] first_v [3];
		logic signed [CW-1:0] second_v [3];
		logic signed [CW-1:0] t_lo;
		logic signed [CW-1:0] t_hi;
	} box_word_t;

	typedef struct {
		logic                 hit;
		logic signed [CW-1:0] near_t;
	} hit_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = CMD_TEST_BOX;
	logic signed [CW-1:0] first_x = '0, first_y = '0, first_z = '0;
	logic signed [CW-1:0] second_x = '0, second_y = '0, second_z = '0;
	logic signed [CW-1:0] t_low = '0, t_high = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic signed [CW-1:0] near_t;

	ray_box_slab_test_core #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
		.first_x(first_x), .first_y(first_y), .first_z(first_z),
		.second_x(second_x), .second_y(second_y), .second_z(second_z),
		.t_low(t_low), .t_high(t_high),
		.out_valid(out_valid), .out_stall(out_stall), .hit(hit), .near_t(near_t)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor copy of the ray held by the block.
	logic signed [CW-1:0] ray_org [3];
	logic signed [CW-1:0] ray_inv [3];
	logic [2:0]           ray_flat;

	box_word_t pending_words [$];
	hit_word_t expected_hits [$];
	int  error_count = 0;
	int  cycle_count = 0;
	bit  stimulus_done = 1'b0;
	bit  calm_phase = 1'b0;
	bit  hold_receiver = 1'b0;
	int  hold_cycles = 0;

	function automatic logic signed [CW-1:0] clamp_wide(logic signed [127:0] v);
		if (v > 128'sd2147483647)
			return 32'sh7fffffff;
		if (v < -128'sd2147483648)
			return 32'sh80000000;
		return v[CW-1:0];
	endfunction

	// (edge - origin) * inv scaled back by the fraction bits, truncated toward zero.
	function automatic logic signed [CW-1:0] slab_dist(logic signed [CW-1:0] edge_v,
			logic signed [CW-1:0] org, logic signed [CW-1:0] inv);
		logic signed [127:0] prod;
		logic signed [127:0] q;
		prod = (128'(signed'(edge_v)) - 128'(signed'(org))) * 128'(signed'(inv));
		q = (prod < 0) ? -((-prod) >>> FB) : (prod >>> FB);
		return clamp_wide(q);
	endfunction

	// Applies one word to the predictor; returns 1 and the result for a box test.
	function automatic bit predict_box(box_word_t w, output hit_word_t r);
		logic signed [CW-1:0] tn, tf, t0, t1, s;
		logic signed [63:0] d, q;
		bit ok;
		if (w.cmd == CMD_LOAD_RAY) begin
			ray_flat = '0;
			for (int i = 0; i < NUM_AXES; i++) begin
				ray_org[i] = w.first_v[i];
				d = 64'(signed'(w.second_v[i]));
				if (d == 0) begin
					ray_inv[i] = '0;
					ray_flat[i] = 1'b1;
				end else begin
					q = (64'sd1 <<< (2 * FB)) / (d < 0 ? -d : d);
					ray_inv[i] = clamp_wide(128'(d < 0 ? -q : q));
				end
			end
			return 1'b0;
		end
		tn = w.t_lo;
		tf = w.t_hi;
		ok = 1'b1;
		for (int i = 0; i < NUM_AXES && ok; i++) begin
			if (ray_flat[i]) begin
				if (ray_org[i] < w.first_v[i] || ray_org[i] > w.second_v[i])
					ok = 1'b0;
			end else begin
				t0 = slab_dist(w.first_v[i], ray_org[i], ray_inv[i]);
				t1 = slab_dist(w.second_v[i], ray_org[i], ray_inv[i]);
				if (ray_inv[i] < 0) begin
					s = t0; t0 = t1; t1 = s;
				end
				if (t0 > tn) tn = t0;
				if (t1 < tf) tf = t1;
			end
			if (tf <= tn) ok = 1'b0;
		end
		r.hit = ok;
		r.near_t = ok ? tn : '0;
		return 1'b1;
	endfunction

	// Appends a word at the tail of the pending queue.
	function automatic void add_word(box_word_t w);
		pending_words = {pending_words, w};
	endfunction

	task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
		$display("error at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
		error_count++;
	endtask

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $urandom;
			default: return $signed($urandom_range(0, 32'h00140000)) - 32'sh000a0000;
		endcase
	endfunction

	function automatic box_word_t make_ray(logic signed [CW-1:0] o, logic signed [CW-1:0] d);
		box_word_t w;
		w.cmd = CMD_LOAD_RAY;
		for (int i = 0; i < 3; i++) begin
			w.first_v[i] = o;
			w.second_v[i] = d;
		end
		w.t_lo = $urandom;
		w.t_hi = $urandom;
		return w;
	endfunction

	function automatic box_word_t make_box(logic signed [CW-1:0] lo, logic signed [CW-1:0] hi,
			logic signed [CW-1:0] tl, logic signed [CW-1:0] th);
		box_word_t w;
		w.cmd = CMD_TEST_BOX;
		for (int i = 0; i < 3; i++) begin
			w.first_v[i] = lo;
			w.second_v[i] = hi;
		end
		w.t_lo = tl;
		w.t_hi = th;
		return w;
	endfunction

	// Random ray with a random direction mix: zero, tiny, huge and ordinary components.
	function automatic box_word_t random_ray();
		box_word_t w;
		w.cmd = CMD_LOAD_RAY;
		for (int i = 0; i < 3; i++) begin
			w.first_v[i] = rand_coord();
			case ($urandom_range(0, 7))
				0: w.second_v[i] = '0;
				1: w.second_v[i] = $signed($urandom_range(0, 6)) - 3;
				2: w.second_v[i] = $urandom;
				default: w.second_v[i] = $signed($urandom_range(0, 32'h00040000))
					- 32'sh00020000;
			endcase
		end
		w.t_lo = $urandom;
		w.t_hi = $urandom;
		return w;
	endfunction

	// Random box, mostly well ordered around the origin region, sometimes inverted.
	function automatic box_word_t random_box();
		box_word_t w;
		logic signed [CW-1:0] a, b;
		w.cmd = CMD_TEST_BOX;
		for (int i = 0; i < 3; i++) begin
			a = rand_coord();
			b = rand_coord();
			if ($urandom_range(0, 9) != 0 && a > b) begin
				w.first_v[i] = b; w.second_v[i] = a;
			end else begin
				w.first_v[i] = a; w.second_v[i] = b;
			end
		end
		case ($urandom_range(0, 3))
			0: begin w.t_lo = 32'sh80000000; w.t_hi = 32'sh7fffffff; end
			1: begin w.t_lo = $urandom; w.t_hi = $urandom; end
			default: begin
				w.t_lo = $signed($urandom_range(0, 32'h00100000)) - 32'sh00080000;
				w.t_hi = w.t_lo + $signed($urandom_range(0, 32'h01000000));
			end
		endcase
		return w;
	endfunction

	// Stimulus: directed corners first, then random rays each followed by a run of mostly box tests.
	initial begin
		int phase_items;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// Box tests against the reset ray, which is all zero but not parallel.
		add_word(make_box(-32'sd65536, 32'sd65536, 32'sh80000000, 32'sh7fffffff));
		add_word(make_box(32'sh80000000, 32'sh7fffffff, 0, 0));
		// Ordinary ray and boxes: hit, miss, inverted box, empty interval.
		add_word(make_ray(-32'sd131072, 32'sd65536));
		add_word(make_box(-32'sd65536, 32'sd65536, 32'sh80000000, 32'sh7fffffff));
		add_word(make_box(32'sd655360, 32'sd720896, 0, 32'sd65536));
		add_word(make_box(32'sd65536, -32'sd65536, 0, 32'sh7fffffff));
		add_word(make_box(-32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536));
		add_word(make_box(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
		// Parallel axes: origin inside and outside the span.
		add_word(make_ray(32'sd0, 32'sd0));
		add_word(make_box(-32'sd1, 32'sd1, 0, 32'sd100));
		add_word(make_box(32'sd1, 32'sd2, 0, 32'sd100));
		add_word(make_box(32'sd0, 32'sd0, 32'sh80000000, 32'sh7fffffff));
		// Tiny directions saturate the reciprocal; extremes drive product saturation.
		add_word(make_ray(32'sh7fffffff, 32'sd1));
		add_word(make_box(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
		add_word(make_ray(32'sh80000000, -32'sd1));
		add_word(make_box(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
		// Huge directions: the reciprocal falls to a value of 2, and the axis is not parallel.
		add_word(make_ray(32'sd0, 32'sh7fffffff));
		add_word(make_box(-32'sd65536, 32'sd65536, -32'sd5, 32'sd5));
		add_word(make_ray(32'sd65536, 32'sh80000000));
		add_word(make_box(-32'sd65536, 32'sd65536, 32'sh80000000, 32'sh7fffffff));
		add_word(make_ray(32'sd65536, -32'sd65536));
		add_word(make_box(-32'sd65536, 32'sd65536, 32'sh80000000, 32'sh7fffffff));
		wait (pending_words.size() == 0);

		for (int k = 0; k < 187; k++) begin
			add_word(random_ray());
			phase_items = $urandom_range(3, 14);
			for (int j = 0; j < phase_items; j++)
				add_word($urandom_range(0, 19) == 0 ? random_ray() : random_box());
			if (k == 40) begin
				// Sender pause: let the block drain before going on.
				wait (pending_words.size() == 0);
				wait (expected_hits.size() == 0);
			end
			if (k == 60) begin
				// Long receiver hold-off while the sender keeps offering words.
				hold_receiver = 1'b1;
				wait (hold_cycles >= 300);
				hold_receiver = 1'b0;
			end
			if (k == 165)
				calm_phase = 1'b1;
			wait (pending_words.size() < 16);
		end
		wait (pending_words.size() == 0);
		stimulus_done = 1'b1;
	end

	// Driver: presents the oldest pending word, with random idle bursts.
	int send_gap = 0;
	always @(posedge clk) begin
		hit_word_t r;
		box_word_t w;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				w = pending_words.pop_front();
				if (predict_box(w, r))
					expected_hits = {expected_hits, r};
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
					send_gap <= $urandom_range(0, 9);
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					w = pending_words[0];
					in_valid <= 1'b1;
					cmd <= w.cmd;
					first_x <= w.first_v[0];
					first_y <= w.first_v[1];
					first_z <= w.first_v[2];
					second_x <= w.second_v[0];
					second_y <= w.second_v[1];
					second_z <= w.second_v[2];
					t_low <= w.t_lo;
					t_high <= w.t_hi;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result and drives random stall bursts.
	int stall_left = 0;
	always @(posedge clk) begin
		hit_word_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_hits.size() == 0) begin
					report_mismatch("unexpected result", {31'b0, hit}, '0);
				end else begin
					want = expected_hits.pop_front();
					if (hit !== want.hit)
						report_mismatch("hit", {31'b0, hit}, {31'b0, want.hit});
					if (near_t !== want.near_t)
						report_mismatch("near_t", near_t, want.near_t);
				end
			end
			if (hold_receiver) begin
				hold_cycles <= hold_cycles + 1;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (!calm_phase && $urandom_range(0, 11) == 0) begin
				stall_left <= $urandom_range(0, 9);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// End of run: drain, allow for latency, then give the verdict or time out.
	initial begin
		fork
			begin
				wait (stimulus_done && expected_hits.size() == 0);
				repeat (50) @(posedge clk);
				if (error_count == 0 && expected_hits.size() == 0)
					$display("SCOREBOARD CLEAN");
				else
					$display("SCOREBOARD MISMATCH");
			end
			begin
				while (cycle_count < LIMIT_CYCLES) begin
					@(posedge clk);
					cycle_count++;
				end
				$display("timeout after %0d cycles", cycle_count);
				$display("SCOREBOARD MISMATCH");
			end
		join_any
		$finish;
	end

endmodule

>>> ray_box_slab_test_core.f
rtl/rbst_pkg.sv
rtl/rbst_recip.sv
rtl/rbst_mul.sv
rtl/ray_box_slab_test_core.sv
tb/tb_ray_box_slab_test_core.sv
